// File: sv/sfma_pkg.sv
// shared constants, types and helpers of the sparse fiber merge-add block
package sfma_pkg;

	localparam int FIFO_DEPTH = 32;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
	localparam int MAX_WIDTH  = 16;
	localparam int NUM_W      = $clog2(MAX_WIDTH + 1);
	localparam int IDX_W      = 32;
	localparam int VAL_W      = 32;
	localparam int KIND_W     = 2;
	localparam int CFG_W      = 5;
	localparam int CFG_IDX_W  = 2;

	localparam logic [KIND_W-1:0] KIND_PUSH_A = 2'd0;
	localparam logic [KIND_W-1:0] KIND_PUSH_B = 2'd1;
	localparam logic [KIND_W-1:0] KIND_STEP   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_MERGE_WIDTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ADDS      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COMPUTE_VALUES = 2'd2;

	localparam logic [CFG_W-1:0] MERGE_WIDTH_RST = 5'd4;
	localparam logic [CFG_W-1:0] MAX_ADDS_RST    = 5'd3;

	typedef struct packed {
		logic [IDX_W-1:0]        index;
		logic signed [VAL_W-1:0] value;
	} entry_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic rd_en;
		logic clear_last;
	} fifo_ctrl_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             last_seen;
		logic             drop;
	} fifo_stat_t;

	typedef struct packed {
		logic                    take_a;
		logic                    take_b;
		logic                    summed;
		logic [IDX_W-1:0]        index;
		logic signed [VAL_W-1:0] value;
	} merge_sel_t;

	function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] ptr);
		wrap_inc = (ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
	endfunction

endpackage

// File: sv/sfma_in_if.sv
// input channel: pushes and merge step requests
interface sfma_in_if;
	logic                             valid;
	logic                             ready;
	logic [sfma_pkg::KIND_W-1:0]      kind;
	logic [sfma_pkg::IDX_W-1:0]       col_index;
	logic signed [sfma_pkg::VAL_W-1:0] elem_value;
	logic                             fiber_end;

	modport source(output valid, kind, col_index, elem_value, fiber_end, input ready);
	modport sink(input valid, kind, col_index, elem_value, fiber_end, output ready);
endinterface

// File: sv/sfma_out_if.sv
// output channel: merged elements and not-ready results
interface sfma_out_if;
	logic                             valid;
	logic                             ready;
	logic                             status;
	logic [sfma_pkg::IDX_W-1:0]       out_index;
	logic signed [sfma_pkg::VAL_W-1:0] out_value;
	logic                             was_summed;
	logic                             end_of_fiber;
	logic                             step_last;
	logic                             overflow;

	modport source(output valid, status, out_index, out_value, was_summed, end_of_fiber,
		step_last, overflow, input ready);
	modport sink(input valid, status, out_index, out_value, was_summed, end_of_fiber,
		step_last, overflow, output ready);
endinterface

// File: sv/sfma_ram.sv
// simple dual-port ram with registered read data
module sfma_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: sv/sfma_fifo.sv
// one fiber fifo: ram storage, read pointer, fill count and last mark
module sfma_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sfma_pkg::fifo_ctrl_t ctrl,
	input  sfma_pkg::entry_t     wr_entry,
	input  logic                 wr_end,
	output sfma_pkg::fifo_stat_t stat,
	output sfma_pkg::entry_t     head
);

	logic [sfma_pkg::CNT_W-1:0] count_q;
	logic [sfma_pkg::PTR_W-1:0] rptr_q;
	logic                       last_q;
	logic                       full;
	logic                       push_ok;
	logic [sfma_pkg::PTR_W:0]   wsum;
	logic [sfma_pkg::PTR_W-1:0] waddr;
	logic [sfma_pkg::PTR_W-1:0] rptr_next;
	logic [$bits(sfma_pkg::entry_t)-1:0] rdata;

	assign full    = (count_q == sfma_pkg::CNT_W'(sfma_pkg::FIFO_DEPTH));
	assign push_ok = ctrl.push && !full;

	// write slot sits count entries ahead of the read pointer
	assign wsum  = (sfma_pkg::PTR_W + 1)'(rptr_q) + (sfma_pkg::PTR_W + 1)'(count_q);
	assign waddr = (wsum >= (sfma_pkg::PTR_W + 1)'(sfma_pkg::FIFO_DEPTH)) ?
		sfma_pkg::PTR_W'(wsum - (sfma_pkg::PTR_W + 1)'(sfma_pkg::FIFO_DEPTH)) :
		sfma_pkg::PTR_W'(wsum);

	// on a pop the ram already fetches the following head
	assign rptr_next = ctrl.pop ? sfma_pkg::wrap_inc(rptr_q) : rptr_q;

	sfma_ram #(
		.DEPTH(sfma_pkg::FIFO_DEPTH),
		.WIDTH($bits(sfma_pkg::entry_t))
	) u_ram (
		.clk  (clk),
		.we   (push_ok),
		.waddr(waddr),
		.wdata(wr_entry),
		.re   (ctrl.rd_en),
		.raddr(rptr_next),
		.rdata(rdata)
	);

	assign head = sfma_pkg::entry_t'(rdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rptr_q  <= '0;
			last_q  <= 1'b0;
		end else begin
			rptr_q  <= rptr_next;
			count_q <= count_q + sfma_pkg::CNT_W'(push_ok) - sfma_pkg::CNT_W'(ctrl.pop);
			if (ctrl.clear_last) begin
				last_q <= 1'b0;
			end else if (push_ok && wr_end) begin
				last_q <= 1'b1;
			end
		end
	end

	assign stat.count     = count_q;
	assign stat.last_seen = last_q;
	assign stat.drop      = ctrl.push && full;

endmodule

// File: sv/sfma_merge_sel.sv
// head compare and saturating add for one merge beat
module sfma_merge_sel (
	input  logic [sfma_pkg::CNT_W-1:0] count_a,
	input  logic [sfma_pkg::CNT_W-1:0] count_b,
	input  sfma_pkg::entry_t           head_a,
	input  sfma_pkg::entry_t           head_b,
	output sfma_pkg::merge_sel_t       sel
);

	logic signed [sfma_pkg::VAL_W:0]   wide;
	logic signed [sfma_pkg::VAL_W-1:0] sat;

	assign wide = {head_a.value[sfma_pkg::VAL_W-1], head_a.value} +
		{head_b.value[sfma_pkg::VAL_W-1], head_b.value};

	always_comb begin
		if (wide[sfma_pkg::VAL_W] != wide[sfma_pkg::VAL_W-1]) begin
			sat = wide[sfma_pkg::VAL_W] ? {1'b1, {(sfma_pkg::VAL_W - 1){1'b0}}} :
				{1'b0, {(sfma_pkg::VAL_W - 1){1'b1}}};
		end else begin
			sat = wide[sfma_pkg::VAL_W-1:0];
		end
	end

	always_comb begin
		sel.take_a = 1'b0;
		sel.take_b = 1'b0;
		sel.summed = 1'b0;
		// an empty side drains the other
		if (count_a == '0) begin
			sel.take_b = 1'b1;
		end else if (count_b == '0) begin
			sel.take_a = 1'b1;
		end else if (head_a.index < head_b.index) begin
			sel.take_a = 1'b1;
		end else if (head_a.index > head_b.index) begin
			sel.take_b = 1'b1;
		end else begin
			sel.take_a = 1'b1;
			sel.take_b = 1'b1;
			sel.summed = 1'b1;
		end
		sel.index = sel.take_a ? head_a.index : head_b.index;
		if (sel.summed) begin
			sel.value = sat;
		end else begin
			sel.value = sel.take_a ? head_a.value : head_b.value;
		end
	end

endmodule

// File: sv/sparse_fiber_merge_add_core.sv
// top level: fiber fifos, merge sequencer, output register and configuration
// a push gives no result; pushes are taken while a result waits
// a merge step: the start state reads both fifo heads, then the merge state registers one
// merged element per cycle while the sink is ready (one ram read per fifo per cycle, next
// head address forwarded on each pop); input stays not ready until the step ends, and a
// ready step with both fifos empty gives none; a not-ready step gives its single result
// reset clears counts, pointers, last marks, overflow; presets config; ram stays undefined
module sparse_fiber_merge_add_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [sfma_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sfma_pkg::CFG_W-1:0]     cfg_data,
	sfma_in_if.sink                        items,
	sfma_out_if.source                     results
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_START,
		S_MERGE
	} state_t;

	state_t state_q;

	logic [sfma_pkg::CFG_W-1:0] merge_width_q;
	logic [sfma_pkg::CFG_W-1:0] max_adds_q;
	logic                       compute_values_q;

	logic [sfma_pkg::NUM_W-1:0] n_q;
	logic [sfma_pkg::NUM_W-1:0] adds_q;
	logic                       overflow_q;

	logic                             out_valid_q;
	logic                             out_status_q;
	logic [sfma_pkg::IDX_W-1:0]       out_index_q;
	logic signed [sfma_pkg::VAL_W-1:0] out_value_q;
	logic                             out_summed_q;
	logic                             out_eof_q;
	logic                             out_step_last_q;
	logic                             out_overflow_q;

	sfma_pkg::fifo_ctrl_t ctrl_a, ctrl_b;
	sfma_pkg::fifo_stat_t stat_a, stat_b;
	sfma_pkg::entry_t     head_a, head_b;
	sfma_pkg::entry_t     wr_entry;
	sfma_pkg::merge_sel_t sel;

	logic                       accept;
	logic                       out_free;
	logic [sfma_pkg::NUM_W-1:0] mw_eff;
	logic [sfma_pkg::CFG_W-1:0] madd_eff;
	logic                       step_ready;
	logic                       both_empty;
	logic                       start_read;
	logic                       start_nr;
	logic                       emit;
	logic [sfma_pkg::CNT_W-1:0] a_after, b_after;
	logic [sfma_pkg::NUM_W-1:0] n_new, adds_new;
	logic                       step_end;
	logic                       fiber_done;

	assign items.ready = (state_q == S_IDLE);
	assign accept      = items.valid && items.ready;
	assign out_free    = !out_valid_q || results.ready;

	assign wr_entry.index = items.col_index;
	assign wr_entry.value = items.elem_value;

	// out-of-range register values clamp
	always_comb begin
		if (merge_width_q == '0) begin
			mw_eff = sfma_pkg::NUM_W'(1);
		end else if (int'(merge_width_q) > sfma_pkg::MAX_WIDTH) begin
			mw_eff = sfma_pkg::NUM_W'(sfma_pkg::MAX_WIDTH);
		end else begin
			mw_eff = sfma_pkg::NUM_W'(merge_width_q);
		end
		madd_eff = (max_adds_q == '0) ? sfma_pkg::CFG_W'(1) : max_adds_q;
	end

	assign step_ready = (int'(stat_a.count) >= int'(mw_eff) || stat_a.last_seen) &&
		(int'(stat_b.count) >= int'(mw_eff) || stat_b.last_seen);
	assign both_empty = (stat_a.count == '0) && (stat_b.count == '0);
	assign start_nr   = (state_q == S_START) && !step_ready;
	assign start_read = (state_q == S_START) && step_ready && !both_empty;
	assign emit       = (state_q == S_MERGE) && out_free;

	sfma_merge_sel u_sel (
		.count_a(stat_a.count),
		.count_b(stat_b.count),
		.head_a (head_a),
		.head_b (head_b),
		.sel    (sel)
	);

	assign a_after    = stat_a.count - sfma_pkg::CNT_W'(sel.take_a);
	assign b_after    = stat_b.count - sfma_pkg::CNT_W'(sel.take_b);
	assign n_new      = n_q + sfma_pkg::NUM_W'(1);
	assign adds_new   = adds_q + sfma_pkg::NUM_W'(sel.summed);
	assign step_end   = (n_new == mw_eff) || (int'(adds_new) == int'(madd_eff)) ||
		((a_after == '0) && (b_after == '0));
	assign fiber_done = (a_after == '0) && (b_after == '0) &&
		stat_a.last_seen && stat_b.last_seen;

	always_comb begin
		ctrl_a.push       = accept && (items.kind == sfma_pkg::KIND_PUSH_A);
		ctrl_b.push       = accept && (items.kind == sfma_pkg::KIND_PUSH_B);
		ctrl_a.pop        = emit && sel.take_a;
		ctrl_b.pop        = emit && sel.take_b;
		ctrl_a.rd_en      = start_read || emit;
		ctrl_b.rd_en      = start_read || emit;
		// empty fiber pair, or the beat that finishes both fibers
		ctrl_a.clear_last = ((state_q == S_START) && step_ready && both_empty) ||
			(emit && step_end && fiber_done);
		ctrl_b.clear_last = ctrl_a.clear_last;
	end

	sfma_fifo u_fifo_a (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl_a),
		.wr_entry(wr_entry),
		.wr_end  (items.fiber_end),
		.stat    (stat_a),
		.head    (head_a)
	);

	sfma_fifo u_fifo_b (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl_b),
		.wr_entry(wr_entry),
		.wr_end  (items.fiber_end),
		.stat    (stat_b),
		.head    (head_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			merge_width_q    <= sfma_pkg::MERGE_WIDTH_RST;
			max_adds_q       <= sfma_pkg::MAX_ADDS_RST;
			compute_values_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				sfma_pkg::CFG_MERGE_WIDTH: begin
					merge_width_q <= cfg_data;
				end
				sfma_pkg::CFG_MAX_ADDS: begin
					max_adds_q <= cfg_data;
				end
				sfma_pkg::CFG_COMPUTE_VALUES: begin
					compute_values_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			n_q             <= '0;
			adds_q          <= '0;
			overflow_q      <= 1'b0;
			out_valid_q     <= 1'b0;
			out_status_q    <= 1'b0;
			out_index_q     <= '0;
			out_value_q     <= '0;
			out_summed_q    <= 1'b0;
			out_eof_q       <= 1'b0;
			out_step_last_q <= 1'b0;
			out_overflow_q  <= 1'b0;
		end else begin
			if (stat_a.drop || stat_b.drop) begin
				overflow_q <= 1'b1;
			end
			if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && (items.kind == sfma_pkg::KIND_STEP)) begin
						state_q <= S_START;
					end
				end
				S_START: begin
					if (start_nr) begin
						if (out_free) begin
							out_valid_q     <= 1'b1;
							out_status_q    <= 1'b1;
							out_index_q     <= '0;
							out_value_q     <= '0;
							out_summed_q    <= 1'b0;
							out_eof_q       <= 1'b0;
							out_step_last_q <= 1'b1;
							out_overflow_q  <= overflow_q;
							state_q         <= S_IDLE;
						end
					end else if (both_empty) begin
						state_q <= S_IDLE;
					end else begin
						n_q     <= '0;
						adds_q  <= '0;
						state_q <= S_MERGE;
					end
				end
				S_MERGE: begin
					if (emit) begin
						out_valid_q     <= 1'b1;
						out_status_q    <= 1'b0;
						out_index_q     <= sel.index;
						out_value_q     <= compute_values_q ? sel.value : '0;
						out_summed_q    <= sel.summed;
						out_eof_q       <= step_end && fiber_done;
						out_step_last_q <= step_end;
						out_overflow_q  <= overflow_q;
						n_q             <= n_new;
						adds_q          <= adds_new;
						if (step_end) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign results.valid        = out_valid_q;
	assign results.status       = out_status_q;
	assign results.out_index    = out_index_q;
	assign results.out_value    = out_value_q;
	assign results.was_summed   = out_summed_q;
	assign results.end_of_fiber = out_eof_q;
	assign results.step_last    = out_step_last_q;
	assign results.overflow     = out_overflow_q;

	// end of fiber only closes a step
	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> (!results.end_of_fiber || results.step_last))
		else $error("end_of_fiber without step_last");

	// a merge beat always pops a non-empty fifo
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> ((sel.take_a && stat_a.count != '0) || (sel.take_b && stat_b.count != '0)))
		else $error("merge beat on empty fifo");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(stat_a.count) <= sfma_pkg::FIFO_DEPTH) &&
		(int'(stat_b.count) <= sfma_pkg::FIFO_DEPTH))
		else $error("fifo count beyond depth");

	a_overflow_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		overflow_q |=> overflow_q)
		else $error("overflow flag cleared");

endmodule
